// ===== rtl/upd_pkg.sv =====
// Package for the URL percent decoder: item types, character constants,
// phase encoding and the per-byte helper functions. No dependencies.
package upd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_PLAIN   = 3'b001,
		PH_PERCENT = 3'b010,
		PH_HEX     = 3'b100
	} phase_t;

	// Results of decoding one byte: count (0 to 2) and the results in order.
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
	} dec_res_t;

	// {is hex digit, digit value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// Top level of the URL percent decoder: input register, escape decoder,
// result queue. Depends on upd_pkg, upd_decode and upd_outq.
//
//  port group | dir | payload            | handshake
//  in         | in  | in_item_t (9 bits) | in_valid / in_stall
//  out        | out | out_item_t (9 bits)| out_valid / out_stall
//
// One byte accepted per cycle while in_stall is low; a result passes through the input
// register and the result queue. A byte with two results sends them in order through
// the single output port of the two-entry queue, which a stalled output can fill.
// Reset clears the escape phase, held digit and all valid state.
// A byte with more results than queue room holds the input register, raising in_stall.
module url_percent_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  upd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output upd_pkg::out_item_t out_data
);
	import upd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	dec_res_t  res;
	logic [1:0] room;
	logic      move_s1;

	assign move_s1  = valid_s1 && (res.cnt <= room);
	assign in_stall = valid_s1 && !move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	upd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (move_s1),
		.res     (res)
	);

	upd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (res),
		.wr_en     (move_s1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/upd_decode.sv =====
// Escape decoder: phase and held digit registers plus the per-byte decode.
// Depends on upd_pkg.
module upd_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  upd_pkg::in_item_t item,
	input  logic             advance,
	output upd_pkg::dec_res_t res
);
	import upd_pkg::*;

	phase_t     phase_q;
	logic [3:0] nibble_q;
	phase_t     phase_d;
	logic [3:0] nibble_d;
	logic [4:0] hx;
	logic [7:0] b;
	logic       last;

	always_comb begin
		b        = item.in_byte;
		last     = item.in_last;
		hx       = hex_digit(b);
		phase_d  = PH_PLAIN;
		nibble_d = nibble_q;
		res      = '0;
		unique case (phase_q)
			PH_PERCENT: begin
				if (b == CH_PERCENT) begin
					res.cnt = 2'd1;
					res.r0  = '{CH_PERCENT, last};
				end else if (!is_alnum(b)) begin
					res.cnt = 2'd2;
					res.r0  = '{CH_PERCENT, 1'b0};
					res.r1  = '{(b == CH_PLUS) ? CH_SPACE : b, last};
				end else if (hx[4] && !last) begin
					phase_d  = PH_HEX;
					nibble_d = hx[3:0];
				end else begin
					res.cnt = 2'd2;
					res.r0  = '{CH_PERCENT, 1'b0};
					res.r1  = '{b, last};
				end
			end
			PH_HEX: begin
				res.cnt = 2'd1;
				res.r0  = '{hx[4] ? {nibble_q, hx[3:0]} : {4'd0, nibble_q}, last};
			end
			default: begin
				if (b == CH_PLUS) begin
					res.cnt = 2'd1;
					res.r0  = '{CH_SPACE, last};
				end else if (b == CH_PERCENT && !last) begin
					phase_d = PH_PERCENT;
				end else begin
					res.cnt = 2'd1;
					res.r0  = '{b, last};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			nibble_q <= 4'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			nibble_q <= nibble_d;
		end
	end

endmodule

// ===== rtl/upd_outq.sv =====
// Two-entry result queue that drives the output channel.
// Takes up to two results per cycle, as far as room allows; depends on upd_pkg.
module upd_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  upd_pkg::dec_res_t wr,
	input  logic              wr_en,
	output logic [1:0]        room,
	output logic              out_valid,
	input  logic              out_stall,
	output upd_pkg::out_item_t out_data
);
	import upd_pkg::*;

	logic [1:0] cnt_q;
	out_item_t  q0_q;
	out_item_t  q1_q;
	logic       pop;
	logic [1:0] rem;
	logic [1:0] add;
	out_item_t  rem0;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = q0_q;
	assign pop       = out_valid && !out_stall;
	assign room      = 2'd2 - cnt_q + {1'b0, pop};
	assign rem       = cnt_q - {1'b0, pop};
	assign rem0      = pop ? q1_q : q0_q;
	assign add       = wr_en ? wr.cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= rem + add;
		end
	end

	always_ff @(posedge clk) begin
		q0_q <= (rem != 2'd0) ? rem0 : wr.r0;
		priority if (rem == 2'd2) begin
			q1_q <= q1_q;
		end else if (rem == 2'd1) begin
			q1_q <= wr.r0;
		end else begin
			q1_q <= wr.r1;
		end
	end

endmodule

// ===== rtl/upd_checker.sv =====
// Port-level checks for the URL percent decoder and the bind that attaches them.
// Depends on upd_pkg and url_percent_decoder.
module upd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input upd_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input upd_pkg::out_item_t out_data
);

	// The input waits only behind pending results.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	// A fresh result comes from an item that passed through the input register into the queue.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled output item changed");

	a_in_stable: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> $stable(in_data))
		else $error("stalled input item changed");

endmodule

bind url_percent_decoder upd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
